// ----- rtl/core/pcx_pkg.sv -----
package pcx_pkg;

	// Default width of the pixel counters
	localparam int PIXEL_COUNT_BITS_DEF = 25;

	// Widest pixel_count register value; wider counters keep this many bits
	localparam int PIXEL_COUNT_REG_BITS = 25;

	localparam int LINE_WIDTH_BITS = 17;
	localparam int PITCH_BITS      = 16;
	localparam int RUN_BITS        = 6;

	// Register indexes of the configuration port
	localparam logic [1:0] CFG_COMPRESSED     = 2'd0;
	localparam logic [1:0] CFG_LINE_WIDTH     = 2'd1;
	localparam logic [1:0] CFG_BYTES_PER_LINE = 2'd2;
	localparam logic [1:0] CFG_PIXEL_COUNT    = 2'd3;

	// Reset values of the registers
	localparam logic                       COMPRESSED_RST     = 1'b1;
	localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RST     = 17'd640;
	localparam logic [PITCH_BITS-1:0]      BYTES_PER_LINE_RST = 16'd640;
	localparam logic [31:0]                PIXEL_COUNT_RST    = 32'd307200;

	// A byte with both top bits set is a run code
	localparam logic [7:0] RUN_CODE_MASK = 8'hc0;

	// Decoder parse phase
	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_DATA = 2'd1,
		PH_SKIP = 2'd2
	} phase_t;

	// Controller states
	typedef enum logic {
		ST_ACCEPT,
		ST_RUN
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic take_byte;
		logic run_step;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slot_free;
		logic run_start;
		logic run_last;
	} dp_status_t;

endpackage

// ----- rtl/core/pcx_ctrl.sv -----
module pcx_ctrl
	import pcx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state: a run longer than one pixel holds the input side
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_ACCEPT: begin
				if (in_valid && status.slot_free && status.run_start) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.slot_free && status.run_last) begin
					state_nxt = ST_ACCEPT;
				end
			end
			default: state_nxt = ST_ACCEPT;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall      = 1'b1;
		cmd.take_byte = 1'b0;
		cmd.run_step  = 1'b0;
		case (state_q)
			ST_ACCEPT: begin
				in_stall      = !status.slot_free;
				cmd.take_byte = in_valid && status.slot_free;
			end
			ST_RUN: begin
				cmd.run_step = status.slot_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ----- rtl/core/pcx_dp.sv -----
module pcx_dp
	import pcx_pkg::*;
#(
	parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF,
	parameter int CFG_W = (PIXEL_COUNT_BITS > LINE_WIDTH_BITS) ? PIXEL_COUNT_BITS
		: LINE_WIDTH_BITS
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [7:0]       data_byte,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       pixel,
	output logic             last_of_run,
	output logic             image_done
);

	localparam int PCB = PIXEL_COUNT_BITS;
	localparam int PC_W = (PCB < PIXEL_COUNT_REG_BITS) ? PCB : PIXEL_COUNT_REG_BITS;
	localparam logic [PCB-1:0] PC_MASK = PCB'((64'd1 << PC_W) - 64'd1);

	// Configuration registers
	logic                       compressed_q;
	logic [LINE_WIDTH_BITS-1:0] line_width_q;
	logic [PITCH_BITS-1:0]      bytes_per_line_q;
	logic [PCB-1:0]             pixel_count_q;

	// Decode state
	phase_t                     phase_q, phase_nxt;
	logic [RUN_BITS-1:0]        pending_q, pending_nxt;
	logic [PCB-1:0]             pixels_done_q;
	logic [LINE_WIDTH_BITS-1:0] line_left_q, line_left_nxt;
	logic [PITCH_BITS-1:0]      skip_left_q, skip_left_nxt;

	// Run repeat state
	logic [RUN_BITS-1:0]        run_left_q, run_left_nxt;
	logic [7:0]                 run_byte_q;

	// Output register
	logic                       out_valid_q;
	logic [7:0]                 pixel_q;
	logic                       last_q;
	logic                       done_q;

	logic                       image_full;
	logic [PCB-1:0]             remain;
	logic [RUN_BITS-1:0]        run_n;
	logic                       acct;
	logic [RUN_BITS-1:0]        acct_n;
	logic                       line_end;
	logic [PITCH_BITS-1:0]      pad;
	logic                       emit;
	logic [7:0]                 emit_pix;
	logic                       emit_last;
	logic                       run_load;
	logic [PCB-1:0]             done_inc;
	logic                       slot_free;

	assign slot_free  = !out_valid_q || !out_stall;
	assign image_full = pixels_done_q >= pixel_count_q;
	assign remain     = pixel_count_q - pixels_done_q;
	assign run_n      = (remain < PCB'(pending_q)) ? remain[RUN_BITS-1:0] : pending_q;
	assign done_inc   = pixels_done_q + PCB'(1);

	// Line accounting for the pixels of one code
	assign line_end = LINE_WIDTH_BITS'(acct_n) >= line_left_q;
	assign pad = ({1'b0, bytes_per_line_q} > line_width_q)
		? PITCH_BITS'({1'b0, bytes_per_line_q} - line_width_q) : '0;

	// Byte decode
	always_comb begin
		phase_nxt     = phase_q;
		pending_nxt   = pending_q;
		line_left_nxt = line_left_q;
		skip_left_nxt = skip_left_q;
		run_left_nxt  = run_left_q;
		acct          = 1'b0;
		acct_n        = '0;
		emit          = 1'b0;
		emit_pix      = data_byte;
		emit_last     = 1'b1;
		run_load      = 1'b0;

		if (cmd.run_step) begin
			emit         = 1'b1;
			emit_pix     = run_byte_q;
			emit_last    = (run_left_q == RUN_BITS'(1));
			run_left_nxt = run_left_q - RUN_BITS'(1);
		end else if (cmd.take_byte && !image_full) begin
			if (!compressed_q) begin
				emit = 1'b1;
			end else begin
				case (phase_q)
					PH_SKIP: begin
						skip_left_nxt = (skip_left_q != '0) ? skip_left_q - PITCH_BITS'(1) : '0;
						if (skip_left_nxt == '0) begin
							phase_nxt = PH_CODE;
						end
					end
					PH_DATA: begin
						acct        = 1'b1;
						acct_n      = pending_q;
						pending_nxt = '0;
						if (run_n != '0) begin
							emit         = 1'b1;
							emit_last    = (run_n == RUN_BITS'(1));
							run_load     = 1'b1;
							run_left_nxt = run_n - RUN_BITS'(1);
						end
					end
					PH_CODE: begin
						if ((data_byte & RUN_CODE_MASK) == RUN_CODE_MASK) begin
							pending_nxt = data_byte[RUN_BITS-1:0];
							phase_nxt   = PH_DATA;
						end else begin
							emit   = 1'b1;
							acct   = 1'b1;
							acct_n = RUN_BITS'(1);
						end
					end
					default: begin
						phase_nxt = PH_CODE;
					end
				endcase
				if (acct) begin
					if (line_end) begin
						line_left_nxt = line_width_q;
						skip_left_nxt = pad;
						phase_nxt     = (pad != '0) ? PH_SKIP : PH_CODE;
					end else begin
						line_left_nxt = line_left_q - LINE_WIDTH_BITS'(acct_n);
						phase_nxt     = PH_CODE;
					end
				end
			end
		end
	end

	// Configuration and decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_q     <= COMPRESSED_RST;
			line_width_q     <= LINE_WIDTH_RST;
			bytes_per_line_q <= BYTES_PER_LINE_RST;
			pixel_count_q    <= PCB'(PIXEL_COUNT_RST) & PC_MASK;
			phase_q          <= PH_CODE;
			pending_q        <= '0;
			pixels_done_q    <= '0;
			line_left_q      <= LINE_WIDTH_RST;
			skip_left_q      <= '0;
			run_left_q       <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COMPRESSED:     compressed_q <= cfg_data[0];
					CFG_LINE_WIDTH:     line_width_q <= cfg_data[LINE_WIDTH_BITS-1:0];
					CFG_BYTES_PER_LINE: bytes_per_line_q <= cfg_data[PITCH_BITS-1:0];
					CFG_PIXEL_COUNT:    pixel_count_q <= cfg_data[PCB-1:0] & PC_MASK;
					default: ;
				endcase
			end
			phase_q     <= phase_nxt;
			pending_q   <= pending_nxt;
			skip_left_q <= skip_left_nxt;
			run_left_q  <= run_left_nxt;
			// writing the line width restarts the line count
			if (cfg_we && cfg_index == CFG_LINE_WIDTH) begin
				line_left_q <= cfg_data[LINE_WIDTH_BITS-1:0];
			end else begin
				line_left_q <= line_left_nxt;
			end
			if (emit) begin
				pixels_done_q <= done_inc;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload and run byte
	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_q <= emit_pix;
			last_q  <= emit_last;
			done_q  <= (done_inc == pixel_count_q);
		end
		if (run_load) begin
			run_byte_q <= data_byte;
		end
	end

	assign status.slot_free = slot_free;
	assign status.run_start = run_load && (run_n != RUN_BITS'(1));
	assign status.run_last  = (run_left_q == RUN_BITS'(1));

	assign out_valid   = out_valid_q;
	assign pixel       = pixel_q;
	assign last_of_run = last_q;
	assign image_done  = done_q;

endmodule

// ----- rtl/core/pcx_rle_line_decoder.sv -----
// PCX 8-bit run-length decoder for the image data that follows the file header.
// One encoded byte is taken per cycle while the output register is free or is
// being drained and no run repeats; a literal, a pass-through byte, a run code,
// a padding byte or a run of one pixel does not stall the input. A run of n
// pixels (n up to 63, cut at pixel_count) leaves the output register one pixel
// per unstalled cycle and holds the input from its data byte to its last pixel.
// The pixel count register is PIXEL_COUNT_BITS wide, up to 25 bits of it hold
// the configured value; configuration writes belong in idle periods only.
module pcx_rle_line_decoder
	import pcx_pkg::*;
#(
	parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF,
	parameter int CFG_W = (PIXEL_COUNT_BITS > LINE_WIDTH_BITS) ? PIXEL_COUNT_BITS
		: LINE_WIDTH_BITS
)
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	// encoded bytes
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	// decoded pixels
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       pixel,
	output logic             last_of_run,
	output logic             image_done
);

	dp_cmd_t    cmd;
	dp_status_t status;

	pcx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pcx_dp #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
		.CFG_W            (CFG_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel       (pixel),
		.last_of_run (last_of_run),
		.image_done  (image_done)
	);

endmodule
